FILE: rtl/rds_pkg.sv
// Shared types, constants and the pixel expansion function for the raster doubler.
package rds_pkg;

    localparam int DEF_MAX_LINE_BYTES = 2048;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int LEN_W      = 12;
    localparam int WORD_W     = 16;

    localparam logic [1:0] REG_DEPTH_MODE     = 2'd0;
    localparam logic [1:0] REG_IN_LINE_BYTES  = 2'd1;
    localparam logic [1:0] REG_OUT_LINE_WORDS = 2'd2;

    localparam logic             RST_DEPTH_MODE     = 1'b0;
    localparam logic [LEN_W-1:0] RST_IN_LINE_BYTES  = 12'd2;
    localparam logic [LEN_W-1:0] RST_OUT_LINE_WORDS = 12'd2;

    localparam logic MODE_DATA = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic DEPTH_1BPP = 1'b0;
    localparam logic DEPTH_8BPP = 1'b1;

    typedef struct packed {
        logic             depth_mode;
        logic [LEN_W-1:0] in_line_bytes;
        logic [LEN_W-1:0] out_line_words;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic              from_ram;
        logic [WORD_W-1:0] word;
        logic              row_copy;
        logic              last_word;
        logic              dropped;
    } t_stage;

    function automatic logic [WORD_W-1:0] expand_byte(input logic [7:0] b, input logic depth);
        logic [WORD_W-1:0] w;
        w = '0;
        if (depth == DEPTH_8BPP) begin
            w = {b, b};
        end else begin
            for (int i = 0; i < 8; i++) begin
                w[2*i +: 2] = {2{b[i]}};
            end
        end
        return w;
    endfunction

endpackage

FILE: rtl/rds_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module rds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/rds_regs.sv
// APB configuration registers of the raster doubler.
module rds_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rds_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [rds_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [rds_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output rds_pkg::t_cfg                  o_cfg
);
    import rds_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.depth_mode     <= RST_DEPTH_MODE;
            r_cfg.in_line_bytes  <= RST_IN_LINE_BYTES;
            r_cfg.out_line_words <= RST_OUT_LINE_WORDS;
        end else if (wr_en) begin
            if (reg_idx == REG_DEPTH_MODE) begin
                r_cfg.depth_mode <= pwdata[0];
            end
            if (reg_idx == REG_IN_LINE_BYTES) begin
                r_cfg.in_line_bytes <= pwdata[LEN_W-1:0];
            end
            if (reg_idx == REG_OUT_LINE_WORDS) begin
                r_cfg.out_line_words <= pwdata[LEN_W-1:0];
            end
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_DEPTH_MODE:     prdata = {{(CFG_DATA_W-1){1'b0}}, r_cfg.depth_mode};
            REG_IN_LINE_BYTES:  prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, r_cfg.in_line_bytes};
            REG_OUT_LINE_WORDS: prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, r_cfg.out_line_words};
            default:            prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/rds_seq.sv
// Line sequencer: expands bytes, drives line store accesses, tracks line and replay state.
module rds_seq #(
    parameter int MAX_LINE_BYTES = rds_pkg::DEF_MAX_LINE_BYTES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rds_pkg::t_cfg                     i_cfg,
    input  logic                              i_accept,
    input  logic                              i_mode,
    input  logic [7:0]                        i_pixel_byte,
    output rds_pkg::t_stage                   o_stage,
    output logic                              o_we,
    output logic [$clog2(MAX_LINE_BYTES)-1:0] o_waddr,
    output logic [rds_pkg::WORD_W-1:0]        o_wdata,
    output logic                              o_re,
    output logic [$clog2(MAX_LINE_BYTES)-1:0] o_raddr
);
    import rds_pkg::*;

    localparam int IW  = $clog2(MAX_LINE_BYTES);
    localparam int LW  = $clog2(MAX_LINE_BYTES + 1);
    localparam int CW  = (LW > LEN_W) ? LW : LEN_W;
    localparam logic [CW-1:0] MAXC = CW'(MAX_LINE_BYTES);
    localparam logic [CW-1:0] ONE  = CW'(1);

    logic [CW-1:0] r_len, r_row;
    logic [CW-1:0] n_len, n_row, cfg_in, cfg_out;
    logic [IW-1:0] r_in_idx, n_in_idx;
    logic [IW-1:0] r_rep_idx, n_rep_idx;
    logic          r_pend, n_pend;
    logic [CW-1:0] in_nxt, rep_nxt;
    logic          in_lt, in_end, in_last, rep_last, row_zero;

    // line and row lengths, registered off the config
    assign cfg_in  = CW'(i_cfg.in_line_bytes);
    assign cfg_out = CW'(i_cfg.out_line_words);
    assign n_len   = (cfg_in == '0) ? ONE : ((cfg_in > MAXC) ? MAXC : cfg_in);
    assign n_row   = (cfg_out < n_len) ? cfg_out : n_len;

    assign in_nxt   = CW'(r_in_idx) + ONE;
    assign rep_nxt  = CW'(r_rep_idx) + ONE;
    assign in_lt    = CW'(r_in_idx) < r_row;
    assign in_end   = in_nxt >= r_len;
    assign in_last  = in_nxt >= r_row;
    assign rep_last = rep_nxt >= r_row;
    assign row_zero = r_row == '0;

    assign o_wdata = expand_byte(i_pixel_byte, i_cfg.depth_mode);
    assign o_waddr = r_in_idx;
    assign o_raddr = r_rep_idx;

    always_comb begin
        o_stage   = '0;
        o_we      = 1'b0;
        o_re      = 1'b0;
        n_in_idx  = r_in_idx;
        n_rep_idx = r_rep_idx;
        n_pend    = r_pend;
        if (i_accept) begin
            if (i_mode == MODE_DATA) begin
                if (r_pend) begin
                    o_stage.valid   = 1'b1;
                    o_stage.dropped = 1'b1;
                end else begin
                    if (in_lt) begin
                        o_we              = 1'b1;
                        o_stage.valid     = 1'b1;
                        o_stage.word      = o_wdata;
                        o_stage.last_word = in_last;
                    end
                    if (in_end) begin
                        n_in_idx  = '0;
                        n_rep_idx = '0;
                        n_pend    = !row_zero;
                    end else begin
                        n_in_idx = in_nxt[IW-1:0];
                    end
                end
            end else if (r_pend) begin
                if (row_zero) begin
                    n_pend    = 1'b0;
                    n_rep_idx = '0;
                end else begin
                    o_re              = 1'b1;
                    o_stage.valid     = 1'b1;
                    o_stage.from_ram  = 1'b1;
                    o_stage.row_copy  = 1'b1;
                    o_stage.last_word = rep_last;
                    if (rep_last) begin
                        n_pend    = 1'b0;
                        n_rep_idx = '0;
                    end else begin
                        n_rep_idx = rep_nxt[IW-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= CW'(RST_IN_LINE_BYTES);
            r_row     <= CW'(RST_OUT_LINE_WORDS);
            r_in_idx  <= '0;
            r_rep_idx <= '0;
            r_pend    <= 1'b0;
        end else begin
            r_len     <= n_len;
            r_row     <= n_row;
            r_in_idx  <= n_in_idx;
            r_rep_idx <= n_rep_idx;
            r_pend    <= n_pend;
        end
    end

endmodule

FILE: rtl/raster_double_scale.sv
// Top level of the 2x raster doubler: registers, sequencer, line store and output stages.
// An accepted beat is registered in the read stage and then in the output register before it shows on the output port.
// Throughput: one input beat per cycle while input ready is high; the line store takes one write or one read per beat.
// Input ready follows output ready through the stage that waits on the line store read.
// Reset clears indices, replay flag and pipeline valids and loads the config defaults; the line store is not cleared.
module raster_double_scale #(
    parameter int MAX_LINE_BYTES = rds_pkg::DEF_MAX_LINE_BYTES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rds_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [rds_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [rds_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_mode,
    input  logic [7:0]                     i_pixel_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [rds_pkg::WORD_W-1:0]     o_out_word,
    output logic                           o_row_copy,
    output logic                           o_last_word,
    output logic                           o_dropped
);
    import rds_pkg::*;

    localparam int IW = $clog2(MAX_LINE_BYTES);

    t_cfg              cfg;
    t_stage            seq_stage;
    t_stage            r_p1;
    logic              we, re, accept, p1_adv;
    logic [IW-1:0]     waddr, raddr;
    logic [WORD_W-1:0] wdata, rdata, p1_word;
    logic              r_o_valid;
    logic [WORD_W-1:0] r_o_word;
    logic              r_o_copy, r_o_last, r_o_drop;

    rds_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rds_seq #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_accept     (accept),
        .i_mode       (i_mode),
        .i_pixel_byte (i_pixel_byte),
        .o_stage      (seq_stage),
        .o_we         (we),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .o_re         (re),
        .o_raddr      (raddr)
    );

    rds_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_LINE_BYTES)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign p1_adv     = !r_o_valid || i_out_ready;
    assign o_in_ready = !r_p1.valid || p1_adv;
    assign accept     = i_in_valid && o_in_ready;
    assign p1_word    = r_p1.from_ram ? rdata : r_p1.word;

    // read stage: ram data lands here in the cycle after the beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1.valid <= 1'b0;
        end else if (o_in_ready) begin
            r_p1.valid <= seq_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_p1.from_ram  <= seq_stage.from_ram;
            r_p1.word      <= seq_stage.word;
            r_p1.row_copy  <= seq_stage.row_copy;
            r_p1.last_word <= seq_stage.last_word;
            r_p1.dropped   <= seq_stage.dropped;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (p1_adv) begin
            r_o_valid <= r_p1.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p1_adv) begin
            r_o_word <= p1_word;
            r_o_copy <= r_p1.row_copy;
            r_o_last <= r_p1.last_word;
            r_o_drop <= r_p1.dropped;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_word  = r_o_word;
    assign o_row_copy  = r_o_copy;
    assign o_last_word = r_o_last;
    assign o_dropped   = r_o_drop;

endmodule

FILE: sim/rds_row_checker.sv
// Checker for the raster doubler: tracks config, predicts each output word and compares beats.
module rds_row_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rds_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [rds_pkg::CFG_DATA_W-1:0] pwdata,
    input  logic                           pready,
    input  logic                           i_in_valid,
    input  logic                           o_in_ready,
    input  logic                           i_mode,
    input  logic [7:0]                     i_pixel_byte,
    input  logic                           o_out_valid,
    input  logic                           i_out_ready,
    input  logic [rds_pkg::WORD_W-1:0]     o_out_word,
    input  logic                           o_row_copy,
    input  logic                           o_last_word,
    input  logic                           o_dropped,
    output int                             o_failures,
    output int                             o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import rds_pkg::*;

    localparam int unsigned LINE_MAX = DEF_MAX_LINE_BYTES;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              copy;
        logic              last;
        logic              drop;
    } t_row_beat;

    t_row_beat         pending_words[$];
    logic [WORD_W-1:0] row_mem [LINE_MAX];
    int unsigned       fill_idx;
    int unsigned       replay_idx;
    logic              replay_busy;
    logic              cfg_depth;
    logic [LEN_W-1:0]  cfg_in_bytes;
    logic [LEN_W-1:0]  cfg_out_words;
    int                mismatches = 0;

    // 1bpp: output bit k takes input bit k/2
    function automatic logic [WORD_W-1:0] double_pixels(input logic [7:0] b, input logic depth);
        logic [WORD_W-1:0] w;
        if (depth == DEPTH_8BPP) begin
            w = {b, b};
        end else begin
            for (int k = 0; k < WORD_W; k++) begin
                w[k] = b[k/2];
            end
        end
        return w;
    endfunction

    task automatic advance_doubler(input logic mode, input logic [7:0] b);
        int unsigned line_n;
        int unsigned row_n;
        t_row_beat   e;
        line_n = (cfg_in_bytes == 0) ? 1 : cfg_in_bytes;
        if (line_n > LINE_MAX) line_n = LINE_MAX;
        row_n = (cfg_out_words < line_n) ? cfg_out_words : line_n;
        e = '0;
        if (mode == MODE_DATA) begin
            if (replay_busy) begin
                e.drop = 1'b1;
                pending_words.push_back(e);
            end else begin
                if (fill_idx < row_n) begin
                    e.word = double_pixels(b, cfg_depth);
                    e.last = (fill_idx + 1 >= row_n);
                    row_mem[fill_idx % LINE_MAX] = e.word;
                    pending_words.push_back(e);
                end
                if (fill_idx + 1 >= line_n) begin
                    fill_idx    = 0;
                    replay_idx  = 0;
                    replay_busy = (row_n > 0);
                end else begin
                    fill_idx++;
                end
            end
        end else if (replay_busy) begin
            if (row_n == 0) begin
                replay_busy = 1'b0;
                replay_idx  = 0;
            end else begin
                e.word = row_mem[replay_idx % LINE_MAX];
                e.copy = 1'b1;
                e.last = (replay_idx + 1 >= row_n);
                pending_words.push_back(e);
                if (e.last) begin
                    replay_busy = 1'b0;
                    replay_idx  = 0;
                end else begin
                    replay_idx++;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_row_beat want;
        logic      bad;
        if (!i_rst_n) begin
            pending_words.delete();
            fill_idx      = 0;
            replay_idx    = 0;
            replay_busy   = 1'b0;
            cfg_depth     = RST_DEPTH_MODE;
            cfg_in_bytes  = RST_IN_LINE_BYTES;
            cfg_out_words = RST_OUT_LINE_WORDS;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_words.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual word %h copy %b last %b dropped %b",
                             $time, o_out_word, o_row_copy, o_last_word, o_dropped);
                    mismatches++;
                end else begin
                    want = pending_words.pop_front();
                    bad  = 1'b0;
                    if (o_out_word !== want.word) begin
                        $display("%0t: out_word expected %h actual %h", $time, want.word, o_out_word);
                        bad = 1'b1;
                    end
                    if (o_row_copy !== want.copy) begin
                        $display("%0t: row_copy expected %b actual %b", $time, want.copy, o_row_copy);
                        bad = 1'b1;
                    end
                    if (o_last_word !== want.last) begin
                        $display("%0t: last_word expected %b actual %b", $time, want.last, o_last_word);
                        bad = 1'b1;
                    end
                    if (o_dropped !== want.drop) begin
                        $display("%0t: dropped expected %b actual %b", $time, want.drop, o_dropped);
                        bad = 1'b1;
                    end
                    if (bad) mismatches++;
                end
            end
            if (i_in_valid && o_in_ready) advance_doubler(i_mode, i_pixel_byte);
            if (psel && penable && pwrite && pready) begin
                case (paddr[CFG_ADDR_W-1:2])
                    REG_DEPTH_MODE:     cfg_depth     = pwdata[0];
                    REG_IN_LINE_BYTES:  cfg_in_bytes  = pwdata[LEN_W-1:0];
                    REG_OUT_LINE_WORDS: cfg_out_words = pwdata[LEN_W-1:0];
                    default: ;
                endcase
            end
        end
        o_failures    <= mismatches;
        o_outstanding <= pending_words.size();
    end

endmodule

FILE: sim/tb.sv
// Testbench top for the raster doubler: clock, reset, config writes, pixel stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rds_pkg::*;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr        = '0;
    logic [CFG_DATA_W-1:0] pwdata       = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_in_valid   = 1'b0;
    logic                  o_in_ready;
    logic                  i_mode       = MODE_DATA;
    logic [7:0]            i_pixel_byte = '0;
    logic                  o_out_valid;
    logic                  i_out_ready  = 1'b0;
    logic [WORD_W-1:0]     o_out_word;
    logic                  o_row_copy;
    logic                  o_last_word;
    logic                  o_dropped;

    int failures;
    int outstanding;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int beats_sent     = 0;
    int cur_in         = RST_IN_LINE_BYTES;
    int cur_out        = RST_OUT_LINE_WORDS;

    raster_double_scale uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_pixel_byte (i_pixel_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_word   (o_out_word),
        .o_row_copy   (o_row_copy),
        .o_last_word  (o_last_word),
        .o_dropped    (o_dropped)
    );

    rds_row_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_pixel_byte  (i_pixel_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_word    (o_out_word),
        .o_row_copy    (o_row_copy),
        .o_last_word   (o_last_word),
        .o_dropped     (o_dropped),
        .o_failures    (failures),
        .o_outstanding (outstanding)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        #2_000_000;
        $display("tb failed");
        $finish;
    end

    // ready is settled at the falling edge and holds up to the next rising edge
    task automatic put(input logic mode, input logic [7:0] b);
        logic ready_seen;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= mode;
        i_pixel_byte <= b;
        do begin
            @(negedge i_clk);
            ready_seen = o_in_ready;
            @(posedge i_clk);
        end while (!ready_seen);
        beats_sent++;
    endtask

    // stop sending, let every expected word arrive, then cover the pipe latency
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input int unsigned val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_cfg(input logic depth, input int in_len, input int out_len);
        drain();
        cfg_write(REG_DEPTH_MODE, depth);
        cfg_write(REG_IN_LINE_BYTES, in_len);
        cfg_write(REG_OUT_LINE_WORDS, out_len);
        cur_in  = in_len;
        cur_out = out_len;
    endtask

    // one raster line plus its replay, with stray ticks and data dropped during replay
    task automatic run_line();
        int rows;
        rows = (cur_out < cur_in) ? cur_out : cur_in;
        for (int i = 0; i < cur_in; i++) begin
            if ($urandom_range(19) == 0) put(MODE_TICK, 8'($urandom_range(255)));
            put(MODE_DATA, 8'($urandom_range(255)));
        end
        for (int j = 0; j < rows; j++) begin
            if ($urandom_range(11) == 0) put(MODE_DATA, 8'($urandom_range(255)));
            put(MODE_TICK, 8'($urandom_range(255)));
        end
        if ($urandom_range(9) == 0) put(MODE_TICK, 8'($urandom_range(255)));
    endtask

    initial begin
        int goal;
        int in_len;
        int out_len;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: 1bpp, two bytes, two words
        put(MODE_DATA, 8'h00);
        put(MODE_DATA, 8'hff);
        put(MODE_TICK, 8'h00);
        put(MODE_TICK, 8'hff);
        put(MODE_TICK, 8'h5a);

        // 8bpp, third byte suppressed, data during replay dropped
        set_cfg(DEPTH_8BPP, 3, 2);
        put(MODE_DATA, 8'haa);
        put(MODE_DATA, 8'h55);
        put(MODE_DATA, 8'hc3);
        put(MODE_DATA, 8'h3c);
        put(MODE_TICK, 8'h00);
        put(MODE_TICK, 8'h00);

        // row shrinks in the middle of a replay
        set_cfg(DEPTH_1BPP, 2, 2);
        put(MODE_DATA, 8'h12);
        put(MODE_DATA, 8'hed);
        put(MODE_TICK, 8'h00);
        drain();
        cfg_write(REG_OUT_LINE_WORDS, 1);
        cur_out = 1;
        put(MODE_TICK, 8'h00);

        set_cfg(DEPTH_1BPP, 2, 1);
        put(MODE_DATA, 8'h81);
        put(MODE_DATA, 8'h7e);
        put(MODE_TICK, 8'h00);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            if (ph == 0) begin
                set_cfg(1'($urandom_range(1)), 300, $urandom_range(1, 40));
                run_line();
            end
            goal = beats_sent + 330;
            while (beats_sent < goal) begin
                if ($urandom_range(9) == 0) in_len = 2;
                else if ($urandom_range(4) == 0) in_len = $urandom_range(13, 64);
                else in_len = $urandom_range(2, 12);
                case ($urandom_range(5))
                    0: out_len = 1;
                    1: out_len = 2048;
                    2: out_len = in_len;
                    default: out_len = $urandom_range(1, in_len + 2);
                endcase
                set_cfg(1'($urandom_range(1)), in_len, out_len);
                repeat ($urandom_range(1, 6)) run_line();
            end
        end

        drain();
        if (failures == 0 && outstanding == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
